// ===== sv/kdit_pkg.sv =====
package kdit_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned IndexW = 12;

  // Request codes carried in the kind field.
  typedef enum logic [KindW-1:0] {
    KIND_MAP   = 2'd0,
    KIND_REV   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request
    logic probe_next;  // step to the next slot
    logic insert;      // write key and slot for a fresh id
    logic rev_rd;      // issue or hold the reverse key read
    logic clr_start;   // start a clearing pass
    logic clr_step;    // clear one slot and advance
    logic res_map_hit;
    logic res_new;
    logic res_full;
    logic res_rev;
    logic res_zero;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  slot_valid;
    logic  key_match;
    logic  wrapped;
    logic  count_full;
    logic  rev_bad;
    logic  clr_last;
  } stat_t;

endpackage

// ===== sv/kdit_if.sv =====
interface kdit_req_if;
  logic                            valid;
  logic                            ready;
  logic [kdit_pkg::KindW-1:0]      kind;
  logic [kdit_pkg::KeyW-1:0]       key;
  logic [kdit_pkg::IndexW-1:0]     index;

  modport source (output valid, kind, key, index, input ready);
  modport sink (input valid, kind, key, index, output ready);
endinterface

interface kdit_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [kdit_pkg::IndexW-1:0]     dense_id;
  logic [kdit_pkg::KeyW-1:0]       key_out;
  logic                            is_new;
  logic                            table_full;
  logic                            bad_index;

  modport source (output valid, dense_id, key_out, is_new, table_full, bad_index,
                  input ready);
  modport sink (input valid, dense_id, key_out, is_new, table_full, bad_index,
                output ready);
endinterface

// ===== sv/kdit_ram.sv =====
module kdit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/kdit_datapath.sv =====
module kdit_datapath #(
  parameter int unsigned Capacity  = 4096,
  parameter int unsigned KeyBits   = 64,
  parameter int unsigned SlotCount = 8192
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kdit_pkg::cmd_t               cmd_i,
  output kdit_pkg::stat_t              stat_o,
  input  logic [kdit_pkg::KindW-1:0]   kind_i,
  input  logic [kdit_pkg::KeyW-1:0]    key_i,
  input  logic [kdit_pkg::IndexW-1:0]  index_i,
  output logic [kdit_pkg::IndexW-1:0]  dense_id_o,
  output logic [kdit_pkg::KeyW-1:0]    key_out_o,
  output logic                         is_new_o,
  output logic                         table_full_o,
  output logic                         bad_index_o
);

  localparam int unsigned IdW   = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned SlotW = $clog2(SlotCount);
  localparam int unsigned EntW  = IdW + 1;  // valid bit and id

  logic [CntW-1:0]    count_q, count_d;
  logic [KeyBits-1:0] key_q;
  logic [kdit_pkg::KindW-1:0] kind_q;
  logic [kdit_pkg::IndexW-1:0] index_q;
  logic [SlotW-1:0]   slot_q, slot_d, home_slot;
  logic [SlotW:0]     steps_q, steps_d;
  logic [SlotW-1:0]   clr_q, clr_d;

  logic               slot_we;
  logic [SlotW-1:0]   slot_waddr;
  logic [EntW-1:0]    slot_wdata, slot_rdata;
  logic               key_we;
  logic [IdW-1:0]     key_raddr;
  logic [KeyBits-1:0] key_rdata;
  logic [IdW-1:0]     cur_id;

  // Home slot from the low bits of the used key; any hash gives the same results.
  // The folded value stays below twice the slot count, so one subtraction
  // brings it into range.
  always_comb begin
    logic [63:0]      wide;
    logic [SlotW-1:0] mix;
    wide = 64'(key_i[KeyBits-1:0]);
    mix  = wide[SlotW-1:0] ^ wide[2*SlotW-1 -: SlotW];
    if (32'(mix) >= SlotCount) home_slot = mix - SlotW'(SlotCount);
    else home_slot = mix;
  end

  // Slot table: valid bit and id per slot.
  assign slot_we    = cmd_i.insert || cmd_i.clr_step;
  assign slot_waddr = cmd_i.clr_step ? clr_q : slot_q;
  assign slot_wdata = cmd_i.clr_step ? '0 : {1'b1, count_q[IdW-1:0]};

  kdit_ram #(.Width(EntW), .Depth(SlotCount)) u_slots (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_q),
    .rdata_o (slot_rdata)
  );

  assign cur_id = slot_rdata[IdW-1:0];

  // Key store indexed by id.
  assign key_we    = cmd_i.insert;
  assign key_raddr = cmd_i.rev_rd ? IdW'(index_q) : slot_rdata[IdW-1:0];

  kdit_ram #(.Width(KeyBits), .Depth(Capacity)) u_keys (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (count_q[IdW-1:0]),
    .wdata_i (key_q),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // Probe, count and clear registers.
  always_comb begin
    slot_d  = slot_q;
    steps_d = steps_q;
    count_d = count_q;
    clr_d   = clr_q;
    if (cmd_i.load) begin
      slot_d  = home_slot;
      steps_d = '0;
    end
    if (cmd_i.probe_next) begin
      slot_d  = (slot_q == SlotW'(SlotCount - 1)) ? '0 : slot_q + SlotW'(1);
      steps_d = steps_q + (SlotW+1)'(1);
    end
    if (cmd_i.insert) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.clr_start) begin
      count_d = '0;
      clr_d   = '0;
    end
    if (cmd_i.clr_step) begin
      clr_d = clr_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      clr_q   <= '0;
      steps_q <= '0;
      slot_q  <= '0;
    end else begin
      count_q <= count_d;
      clr_q   <= clr_d;
      steps_q <= steps_d;
      slot_q  <= slot_d;
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      key_q   <= key_i[KeyBits-1:0];
      index_q <= index_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_map_hit) begin
      dense_id_o   <= kdit_pkg::IndexW'(32'(cur_id));
      key_out_o    <= '0;
      is_new_o     <= 1'b0;
      table_full_o <= 1'b0;
      bad_index_o  <= 1'b0;
    end else if (cmd_i.res_new) begin
      dense_id_o   <= kdit_pkg::IndexW'(32'(count_q));
      key_out_o    <= '0;
      is_new_o     <= 1'b1;
      table_full_o <= 1'b0;
      bad_index_o  <= 1'b0;
    end else if (cmd_i.res_full) begin
      dense_id_o   <= '0;
      key_out_o    <= '0;
      is_new_o     <= 1'b0;
      table_full_o <= 1'b1;
      bad_index_o  <= 1'b0;
    end else if (cmd_i.res_rev) begin
      dense_id_o   <= '0;
      key_out_o    <= stat_o.rev_bad ? '0 : kdit_pkg::KeyW'(key_rdata);
      is_new_o     <= 1'b0;
      table_full_o <= 1'b0;
      bad_index_o  <= stat_o.rev_bad;
    end else if (cmd_i.res_zero) begin
      dense_id_o   <= '0;
      key_out_o    <= '0;
      is_new_o     <= 1'b0;
      table_full_o <= 1'b0;
      bad_index_o  <= 1'b0;
    end
  end

  // Status for the controller.
  assign stat_o.kind       = kdit_pkg::kind_e'(kind_q);
  assign stat_o.slot_valid = slot_rdata[EntW-1];
  assign stat_o.key_match  = (key_rdata == key_q);
  assign stat_o.wrapped    = (steps_q >= (SlotW+1)'(SlotCount - 1));
  assign stat_o.count_full = (32'(count_q) >= Capacity);
  assign stat_o.rev_bad    = (32'(index_q) >= 32'(count_q)) || (32'(index_q) >= Capacity);
  assign stat_o.clr_last   = (clr_q == SlotW'(SlotCount - 1));

endmodule

// ===== sv/kdit_ctrl.sv =====
module kdit_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  kdit_pkg::stat_t stat_i,
  output kdit_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_WAIT_SLOT, ST_WAIT_KEY, ST_REV, ST_CLR_REQ
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   res_load;

  // The result register may be reloaded when it is empty or being taken.
  assign out_free    = !out_valid_q || out_ready_i;
  assign res_load    = cmd_o.res_map_hit || cmd_o.res_new || cmd_o.res_full ||
                       cmd_o.res_rev || cmd_o.res_zero;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Commands decoded from the state and status. A finished request waits in
  // its state while the previous result is still held.
  always_comb begin
    cmd_o      = '0;
    cmd_o.load = in_ready_o && in_valid_i;
    unique case (state_q)
      ST_CLEAR, ST_CLR_REQ: cmd_o.clr_step = 1'b1;
      ST_IDLE: ;
      ST_DECODE: begin
        unique case (stat_i.kind)
          kdit_pkg::KIND_MAP:   ;
          kdit_pkg::KIND_REV:   cmd_o.rev_rd = 1'b1;
          kdit_pkg::KIND_CLEAR: begin
            cmd_o.clr_start = out_free;
            cmd_o.res_zero  = out_free;
          end
          default: cmd_o.res_zero = out_free;
        endcase
      end
      ST_WAIT_SLOT: begin
        if (!stat_i.slot_valid && out_free) begin
          if (stat_i.count_full) cmd_o.res_full = 1'b1;
          else begin
            cmd_o.insert  = 1'b1;
            cmd_o.res_new = 1'b1;
          end
        end
      end
      ST_WAIT_KEY: begin
        if (stat_i.key_match) cmd_o.res_map_hit = out_free;
        else if (stat_i.wrapped) cmd_o.res_full = out_free;
        else cmd_o.probe_next = 1'b1;
      end
      ST_REV: begin
        cmd_o.rev_rd  = 1'b1;
        cmd_o.res_rev = out_free;
      end
      default: ;
    endcase
  end

  // State and result-valid register. The slot read and the key read settle
  // in separate cycles and the compare follows, so each probe of an occupied
  // slot passes through ST_DECODE, ST_WAIT_SLOT and ST_WAIT_KEY.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (res_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR, ST_CLR_REQ: if (stat_i.clr_last) state_q <= ST_IDLE;
        ST_IDLE: if (cmd_o.load) state_q <= ST_DECODE;
        ST_DECODE: begin
          unique case (stat_i.kind)
            kdit_pkg::KIND_MAP:   state_q <= ST_WAIT_SLOT;
            kdit_pkg::KIND_REV:   state_q <= ST_REV;
            kdit_pkg::KIND_CLEAR: if (out_free) state_q <= ST_CLR_REQ;
            default:              if (out_free) state_q <= ST_IDLE;
          endcase
        end
        ST_WAIT_SLOT: begin
          if (stat_i.slot_valid) state_q <= ST_WAIT_KEY;
          else if (out_free) state_q <= ST_IDLE;
        end
        ST_WAIT_KEY: begin
          if (cmd_o.probe_next) state_q <= ST_DECODE;
          else if (out_free) state_q <= ST_IDLE;
        end
        ST_REV: if (out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/key_to_dense_id_interning_table_core.sv =====
// Interns keys as dense ids. A map request probes an open-addressed slot
// table linearly from a home slot. Each occupied slot probed passes a slot
// read, a key read and a compare; a free slot ends a miss with a fresh id,
// or with a refusal when the id count is full, and a full wrap of the table
// ends it with a refusal. After reset, and on every clear request, a
// clearing pass walks the slot table one slot a cycle, during which no
// transaction is accepted. The result is held in an output register, so the
// next request may be accepted while it waits; that request then holds
// before its own result until the register has been taken.
module key_to_dense_id_interning_table_core #(
  parameter int unsigned CAPACITY   = 4096,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned SLOT_COUNT = 8192
) (
  input logic        clk_i,
  input logic        rst_ni,
  kdit_req_if.sink   req,
  kdit_rsp_if.source rsp
);

  kdit_pkg::cmd_t  cmd;
  kdit_pkg::stat_t stat;

  // Controller.
  kdit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath with both tables.
  kdit_datapath #(
    .Capacity  (CAPACITY),
    .KeyBits   (KEY_BITS),
    .SlotCount (SLOT_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (req.kind),
    .key_i        (req.key),
    .index_i      (req.index),
    .dense_id_o   (rsp.dense_id),
    .key_out_o    (rsp.key_out),
    .is_new_o     (rsp.is_new),
    .table_full_o (rsp.table_full),
    .bad_index_o  (rsp.bad_index)
  );

endmodule
